FILE: hw/rtl/cc20_pkg.sv
// Shared types, constants and helpers for the ChaCha20 byte-stream core.
package cc20_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  // Configuration register indexes (byte address = 8 * index)
  localparam logic [2:0] REG_KEY_0_1   = 3'd0;
  localparam logic [2:0] REG_KEY_2_3   = 3'd1;
  localparam logic [2:0] REG_KEY_4_5   = 3'd2;
  localparam logic [2:0] REG_KEY_6_7   = 3'd3;
  localparam logic [2:0] REG_NONCE_0_1 = 3'd4;
  localparam logic [2:0] REG_NONCE_2   = 3'd5;
  localparam logic [2:0] REG_CTR       = 3'd6;

  typedef struct packed {
    word_t [7:0] key;
    word_t [2:0] nonce;
  } cfg_t;

  // One quarter-round line per step; all four lanes run in parallel.
  typedef enum logic [1:0] {
    STEP_AB16 = 2'd0,
    STEP_CD12 = 2'd1,
    STEP_AB8  = 2'd2,
    STEP_CD7  = 2'd3
  } qr_step_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_FINAL = 2'd2,
    ST_EMIT  = 2'd3
  } ctrl_state_e;

  typedef struct packed {
    logic     load_init;   // latch input word, load working block
    logic     round_en;    // apply one quarter-round line
    logic     diag;        // diagonal round when set
    qr_step_e step;
    logic     final_add;   // keystream = working + init, counter++
    logic     out_direct;  // output from input port and current keystream
    logic     out_gen;     // output from held word after generation
  } dp_cmd_t;

  typedef struct packed {
    logic pos_zero;
  } dp_status_t;

  function automatic word_t rotl(word_t x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

endpackage

FILE: hw/rtl/cc20_ctrl.sv
// Sequencer for the ChaCha20 core: handshakes, round counting, output valid.
module cc20_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  cc20_pkg::dp_status_t status_i,
  output cc20_pkg::dp_cmd_t    cmd_o
);
  import cc20_pkg::*;

  localparam int unsigned DrW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DrW-1:0] DrLast = DrW'(DOUBLE_ROUNDS - 1);

  ctrl_state_e    state_q, state_d;
  qr_step_e       step_q, step_d;
  logic           half_q, half_d;
  logic [DrW-1:0] dr_q, dr_d;
  logic           valid_q, valid_d;
  logic           out_free, out_load;

  assign out_free  = !valid_q || m_ready_i;
  assign m_valid_o = valid_q;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    half_d    = half_q;
    dr_d      = dr_q;
    s_ready_o = 1'b0;
    out_load  = 1'b0;
    cmd_o     = '0;
    cmd_o.step = STEP_AB16;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = out_free;
        if (s_valid_i && out_free) begin
          if (status_i.pos_zero) begin
            cmd_o.load_init = 1'b1;
            step_d  = STEP_AB16;
            half_d  = 1'b0;
            dr_d    = '0;
            state_d = ST_ROUND;
          end else begin
            cmd_o.out_direct = 1'b1;
            out_load = 1'b1;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        cmd_o.diag     = half_q;
        cmd_o.step     = step_q;
        step_d = qr_step_e'(step_q + 2'd1);
        if (step_q == STEP_CD7) begin
          half_d = !half_q;
          if (half_q) begin
            if (dr_q == DrLast) begin
              dr_d    = '0;
              state_d = ST_FINAL;
            end else begin
              dr_d = dr_q + 1'b1;
            end
          end
        end
      end
      ST_FINAL: begin
        cmd_o.final_add = 1'b1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd_o.out_gen = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    valid_d = out_load || (valid_q && !m_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_AB16;
      half_q  <= 1'b0;
      dr_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      half_q  <= half_d;
      dr_q    <= dr_d;
      valid_q <= valid_d;
    end
  end

endmodule

FILE: hw/rtl/cc20_dp.sv
// ChaCha20 datapath: working block, keystream block, counter, byte position.
module cc20_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cc20_pkg::cfg_t       cfg_i,
  input  logic                 ctr_load_i,
  input  logic [31:0]          ctr_value_i,
  input  cc20_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output logic [7:0]           out_byte_o,
  output logic                 out_last_o,
  output cc20_pkg::dp_status_t status_o
);
  import cc20_pkg::*;

  block_t      init;
  block_t      work_q, work_d;
  block_t      ks_q;
  word_t       ctr_q;
  logic [5:0]  pos_q;
  logic [7:0]  hold_byte_q;
  logic        hold_last_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  word_t       ks_word;
  logic [7:0]  ks_byte;
  logic        sel_last;

  assign status_o.pos_zero = (pos_q == 6'd0);
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

  // Input state of the block function
  always_comb begin
    init[0] = SIGMA_0;
    init[1] = SIGMA_1;
    init[2] = SIGMA_2;
    init[3] = SIGMA_3;
    for (int i = 0; i < 8; i++) begin
      init[4 + i] = cfg_i.key[i];
    end
    init[12] = ctr_q;
    init[13] = cfg_i.nonce[0];
    init[14] = cfg_i.nonce[1];
    init[15] = cfg_i.nonce[2];
  end

  // One line of the quarter round on all four lanes
  always_comb begin
    logic [3:0] ia, ib, ic, id;
    logic [1:0] ln;
    word_t      sum;
    work_d = work_q;
    for (int j = 0; j < 4; j++) begin
      ln  = 2'(j);
      ia  = {2'b00, ln};
      ib  = {2'b01, ln + (cmd_i.diag ? 2'd1 : 2'd0)};
      ic  = {2'b10, ln + (cmd_i.diag ? 2'd2 : 2'd0)};
      id  = {2'b11, ln + (cmd_i.diag ? 2'd3 : 2'd0)};
      sum = '0;
      unique case (cmd_i.step)
        STEP_AB16: begin
          sum = work_q[ia] + work_q[ib];
          work_d[ia] = sum;
          work_d[id] = rotl(work_q[id] ^ sum, 16);
        end
        STEP_CD12: begin
          sum = work_q[ic] + work_q[id];
          work_d[ic] = sum;
          work_d[ib] = rotl(work_q[ib] ^ sum, 12);
        end
        STEP_AB8: begin
          sum = work_q[ia] + work_q[ib];
          work_d[ia] = sum;
          work_d[id] = rotl(work_q[id] ^ sum, 8);
        end
        STEP_CD7: begin
          sum = work_q[ic] + work_q[id];
          work_d[ic] = sum;
          work_d[ib] = rotl(work_q[ib] ^ sum, 7);
        end
        default: sum = '0;
      endcase
    end
  end

  assign ks_word  = ks_q[pos_q[5:2]];
  assign ks_byte  = ks_word[{pos_q[1:0], 3'b000} +: 8];
  assign sel_last = cmd_i.out_gen ? hold_last_q : in_last_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_init) begin
      work_q      <= init;
      hold_byte_q <= in_byte_i;
      hold_last_q <= in_last_i;
    end else if (cmd_i.round_en) begin
      work_q <= work_d;
    end
    if (cmd_i.final_add) begin
      for (int i = 0; i < 16; i++) begin
        ks_q[i] <= work_q[i] + init[i];
      end
    end
    if (cmd_i.out_direct) begin
      out_byte_q <= in_byte_i ^ ks_byte;
      out_last_q <= in_last_i;
    end else if (cmd_i.out_gen) begin
      out_byte_q <= hold_byte_q ^ ks_byte;
      out_last_q <= hold_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.final_add) begin
        ctr_q <= ctr_q + 32'd1;
      end
      if (cmd_i.out_direct || cmd_i.out_gen) begin
        pos_q <= sel_last ? 6'd0 : pos_q + 6'd1;
      end
      if (ctr_load_i) begin
        ctr_q <= ctr_value_i;
        pos_q <= '0;
      end
    end
  end

endmodule

FILE: hw/rtl/chacha20_stream_cipher_core.sv
// ChaCha20 byte-stream cipher core: register file, sequencer and datapath.
//
// Usage: program key, nonce and the starting block counter over the APB
// port (registers 8 bytes apart at byte addresses 0x00..0x30), then stream
// bytes in on the slave side; each output word is the input byte XOR
// keystream, with tlast copied through. Writing the counter register also
// restarts the keystream at the beginning of a fresh 64-byte block. tlast
// on input drops the rest of the current block; the next byte starts a new one.
// Throughput: bytes 1..63 of a block are taken one per cycle while the output
// register is free. The first byte of a block waits for generation: one
// quarter-round line per step on all four lanes in parallel, then the
// feed-forward add, then the emit. A mid-block byte is XORed and registered
// straight into the output register. Output is a single register; the slave
// side is ready only in idle and while it is empty or being drained, so a
// stalled receiver holds the core after one pending word. Reset clears the
// counter, byte position, registers (all zero) and the output valid.
module chacha20_stream_cipher_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_message
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import cc20_pkg::*;

  logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
  logic [31:0] nonce2_q, ctr_init_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  cfg_t        cfg;
  dp_cmd_t     cmd;
  dp_status_t  status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key01_q    <= '0;
      key23_q    <= '0;
      key45_q    <= '0;
      key67_q    <= '0;
      nonce01_q  <= '0;
      nonce2_q   <= '0;
      ctr_init_q <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_0_1:   key01_q    <= pwdata;
        REG_KEY_2_3:   key23_q    <= pwdata;
        REG_KEY_4_5:   key45_q    <= pwdata;
        REG_KEY_6_7:   key67_q    <= pwdata;
        REG_NONCE_0_1: nonce01_q  <= pwdata;
        REG_NONCE_2:   nonce2_q   <= pwdata[31:0];
        REG_CTR:       ctr_init_q <= pwdata[31:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_0_1:   prdata = key01_q;
      REG_KEY_2_3:   prdata = key23_q;
      REG_KEY_4_5:   prdata = key45_q;
      REG_KEY_6_7:   prdata = key67_q;
      REG_NONCE_0_1: prdata = nonce01_q;
      REG_NONCE_2:   prdata = {32'd0, nonce2_q};
      REG_CTR:       prdata = {32'd0, ctr_init_q};
      default:       prdata = '0;
    endcase
  end

  // Low word of each pair is the lower-numbered key/nonce word
  assign cfg.key[0]   = key01_q[31:0];
  assign cfg.key[1]   = key01_q[63:32];
  assign cfg.key[2]   = key23_q[31:0];
  assign cfg.key[3]   = key23_q[63:32];
  assign cfg.key[4]   = key45_q[31:0];
  assign cfg.key[5]   = key45_q[63:32];
  assign cfg.key[6]   = key67_q[31:0];
  assign cfg.key[7]   = key67_q[63:32];
  assign cfg.nonce[0] = nonce01_q[31:0];
  assign cfg.nonce[1] = nonce01_q[63:32];
  assign cfg.nonce[2] = nonce2_q;

  cc20_ctrl #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cc20_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctr_load_i  (wr_en && (reg_idx == REG_CTR)),
    .ctr_value_i (pwdata[31:0]),
    .cmd_i       (cmd),
    .in_byte_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .status_o    (status)
  );

  // A byte at block start kicks off keystream generation next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && status.pos_zero) |=> cmd.round_en)
    else $error("generation did not start after block-start byte");

  // No new byte is taken while rounds are running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round_en |-> !s_axis_tready)
    else $error("input ready during keystream generation");

  // Every output load raises the output valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_gen || cmd.out_direct) |=> m_axis_tvalid)
    else $error("output loaded without valid");

endmodule
